/* design/vzc_pkg.sv */
// shared types and constants for the varint zigzag codec
package vzc_pkg;

    localparam int FIELD_W    = 32;
    localparam int COUNT_W    = 3;
    localparam int BYTE_W     = 8;
    localparam int GROUP_BITS = 7;

    localparam logic       CMD_ENCODE = 1'b0;
    localparam logic       CMD_DECODE = 1'b1;
    localparam logic [7:0] CONT_BIT   = 8'h80;

    typedef struct packed {
        logic               cmd;
        logic               is_signed;
        logic [FIELD_W-1:0] value_in;
        logic [BYTE_W-1:0]  data_byte;
        logic               end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic               is_value;
        logic [BYTE_W-1:0]  out_byte;
        logic [FIELD_W-1:0] value_out;
        logic [COUNT_W-1:0] byte_count;
        logic               last;
        logic               unterminated;
        logic               too_long;
    } out_item_t;

    typedef struct packed {
        logic               step;
        logic               is_signed;
        logic [BYTE_W-1:0]  data_byte;
        logic               end_of_buffer;
    } dec_cmd_t;

    typedef struct packed {
        logic               fire;
        logic [FIELD_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               unterminated;
        logic               too_long;
    } dec_result_t;

endpackage

/* design/vzc_decoder.sv */
// decode accumulator: gathers seven-bit groups and ends a value
module vzc_decoder
    import vzc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dec_cmd_t    cmd,
    output dec_result_t result
);

    localparam int EFF_W      = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
    localparam int MAX_GROUPS = (EFF_W + GROUP_BITS - 1) / GROUP_BITS;
    localparam int SPAN_W     = GROUP_BITS * MAX_GROUPS;
    localparam logic [COUNT_W-1:0] GROUP_LIMIT = COUNT_W'(MAX_GROUPS);

    logic [EFF_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0] gi_reg, gi_next;

    logic [COUNT_W-1:0] gi_eff;
    logic [COUNT_W-1:0] gi_new;
    logic [SPAN_W-1:0]  grp_span;
    logic [EFF_W-1:0]   acc_new;
    logic [EFF_W-1:0]   dec_value;
    logic               more;
    logic               tl;
    logic               unt;
    logic               fire;

    always_comb begin
        gi_eff   = (gi_reg >= GROUP_LIMIT) ? '0 : gi_reg;
        grp_span = SPAN_W'(cmd.data_byte[GROUP_BITS-1:0]) << (GROUP_BITS * int'(gi_eff));
        acc_new  = acc_reg | grp_span[EFF_W-1:0];
        gi_new   = gi_eff + COUNT_W'(1);
        more     = cmd.data_byte[BYTE_W-1];
        tl       = more && (gi_new >= GROUP_LIMIT);
        unt      = more && cmd.end_of_buffer;
        fire     = !more || tl || unt;
        if (cmd.is_signed) begin
            dec_value = (acc_new >> 1) ^ {EFF_W{acc_new[0]}};
        end else begin
            dec_value = acc_new;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        gi_next  = gi_reg;
        if (cmd.step) begin
            if (fire) begin
                acc_next = '0;
                gi_next  = '0;
            end else begin
                acc_next = acc_new;
                gi_next  = gi_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            gi_reg  <= '0;
        end else begin
            acc_reg <= acc_next;
            gi_reg  <= gi_next;
        end
    end

    assign result.fire         = cmd.step && fire;
    assign result.value        = FIELD_W'(dec_value);
    assign result.count        = gi_new;
    assign result.unterminated = unt;
    assign result.too_long     = tl;

endmodule

/* design/varint_zigzag_codec_unit.sv */
// top level of the varint (LEB128) codec with optional zigzag mapping
//
// input channel s_*: one item per transfer. cmd encode takes value_in and
// gives one to five encoded bytes; cmd decode takes one data_byte and gives
// a decoded value when that byte ends the value (no continuation bit, buffer
// end, or the byte limit reached), otherwise nothing.
// result channel m_*: one result per transfer, in order.
// each item is registered in the work register, then its results in the
// result register. throughput: while the result register is free, decode
// takes one byte per cycle and an encode gives one byte a cycle; an encode
// holds the work register until all its bytes (1 to 5) are given, and the
// next item is taken in the cycle its last byte moves on.
// reset clears the decode accumulator, the work stage and the result
// register. while m_valid is high and m_ready low the result register holds
// and the work stage stops; s_ready is low while the work stage holds an item that is not done.
module varint_zigzag_codec_unit
    import vzc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int EFF_W      = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
    localparam int MAX_GROUPS = (EFF_W + GROUP_BITS - 1) / GROUP_BITS;
    localparam logic [COUNT_W-1:0] LAST_N = COUNT_W'(MAX_GROUPS - 1);

    logic               work_valid_reg, work_valid_next;
    logic               work_cmd_reg, work_cmd_next;
    logic               work_sgn_reg, work_sgn_next;
    logic [EFF_W-1:0]   work_resid_reg, work_resid_next;
    logic [BYTE_W-1:0]  work_byte_reg, work_byte_next;
    logic               work_eob_reg, work_eob_next;
    logic [COUNT_W-1:0] work_n_reg, work_n_next;

    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               out_free;
    logic               adv;
    logic               enc_final;
    logic               work_done;
    logic               load;
    logic [EFF_W-1:0]   vin;
    logic [EFF_W-1:0]   vin_mapped;
    logic [BYTE_W-1:0]  enc_byte;
    dec_cmd_t           dec_cmd;
    dec_result_t        dec_res;

    // handshake and work stage control
    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        adv       = work_valid_reg && out_free;
        enc_final = ((work_resid_reg >> GROUP_BITS) == '0) || (work_n_reg == LAST_N);
        work_done = adv && ((work_cmd_reg == CMD_DECODE) || enc_final);
        s_ready   = !work_valid_reg || work_done;
        load      = s_valid && s_ready;
    end

    // zigzag map on the way in
    always_comb begin
        vin = s_data.value_in[EFF_W-1:0];
        if (s_data.is_signed) begin
            vin_mapped = {vin[EFF_W-2:0], 1'b0} ^ {EFF_W{vin[EFF_W-1]}};
        end else begin
            vin_mapped = vin;
        end
    end

    always_comb begin
        work_valid_next = work_valid_reg;
        work_cmd_next   = work_cmd_reg;
        work_sgn_next   = work_sgn_reg;
        work_resid_next = work_resid_reg;
        work_byte_next  = work_byte_reg;
        work_eob_next   = work_eob_reg;
        work_n_next     = work_n_reg;
        if (load) begin
            work_valid_next = 1'b1;
            work_cmd_next   = s_data.cmd;
            work_sgn_next   = s_data.is_signed;
            work_resid_next = vin_mapped;
            work_byte_next  = s_data.data_byte;
            work_eob_next   = s_data.end_of_buffer;
            work_n_next     = '0;
        end else if (work_done) begin
            work_valid_next = 1'b0;
        end else if (adv) begin
            work_resid_next = work_resid_reg >> GROUP_BITS;
            work_n_next     = work_n_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_cmd_reg   <= work_cmd_next;
        work_sgn_reg   <= work_sgn_next;
        work_resid_reg <= work_resid_next;
        work_byte_reg  <= work_byte_next;
        work_eob_reg   <= work_eob_next;
        work_n_reg     <= work_n_next;
    end

    assign dec_cmd.step          = adv && (work_cmd_reg == CMD_DECODE);
    assign dec_cmd.is_signed     = work_sgn_reg;
    assign dec_cmd.data_byte     = work_byte_reg;
    assign dec_cmd.end_of_buffer = work_eob_reg;

    vzc_decoder #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_decoder (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (dec_cmd),
        .result (dec_res)
    );

    // result register
    always_comb begin
        if (enc_final) begin
            enc_byte = {1'b0, work_resid_reg[GROUP_BITS-1:0]};
        end else begin
            enc_byte = CONT_BIT | {1'b0, work_resid_reg[GROUP_BITS-1:0]};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv && (work_cmd_reg == CMD_ENCODE)) begin
            m_valid_next             = 1'b1;
            m_data_next.is_value     = 1'b0;
            m_data_next.out_byte     = enc_byte;
            m_data_next.value_out    = '0;
            m_data_next.byte_count   = work_n_reg + COUNT_W'(1);
            m_data_next.last         = enc_final;
            m_data_next.unterminated = 1'b0;
            m_data_next.too_long     = 1'b0;
        end else if (dec_res.fire) begin
            m_valid_next             = 1'b1;
            m_data_next.is_value     = 1'b1;
            m_data_next.out_byte     = '0;
            m_data_next.value_out    = dec_res.value;
            m_data_next.byte_count   = dec_res.count;
            m_data_next.last         = 1'b1;
            m_data_next.unterminated = dec_res.unterminated;
            m_data_next.too_long     = dec_res.too_long;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/vzc_checker.sv */
// port level checks for the varint zigzag codec, bound to the top level
module vzc_checker
    import vzc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // decoded values are always a single final result with a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_value |-> m_data.last && (m_data.byte_count != '0))
        else $error("bad decode result framing");

    // encoded bytes carry continuation exactly when not last
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_value |-> (m_data.out_byte[7] != m_data.last))
        else $error("continuation bit does not match last");

endmodule

bind varint_zigzag_codec_unit vzc_checker u_vzc_checker (.*);

/* tb/varint_zigzag_codec_unit_test.sv */
// testbench for varint_zigzag_codec_unit: encode and decode traffic checked against a predictor
module varint_zigzag_codec_unit_test;
    import vzc_pkg::*;

    localparam int MAX_GROUPS = (FIELD_W + GROUP_BITS - 1) / GROUP_BITS;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t  items_to_send[$];
    out_item_t pending_results[$];

    logic [FIELD_W-1:0] dec_acc = '0;
    int dec_groups = 0;

    bit in_xfer = 0;
    bit out_xfer = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int tx_gap_max = 3;
    int rx_gap_max = 3;
    int hold_left = 0;
    bit hold_done = 0;

    int errors = 0;
    int items_queued = 0;
    int results_checked = 0;
    int n_encodes = 0;
    int n_enc_bytes = 0;
    int n_dec_bytes = 0;
    int n_values = 0;
    int n_unterm = 0;
    int n_too_long = 0;

    varint_zigzag_codec_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void predict_varint(in_item_t it);
        out_item_t r;
        logic [FIELD_W-1:0] v;
        logic [FIELD_W-1:0] grp;
        logic more, tl, unt;
        int n;
        r = '0;
        if (it.cmd == CMD_ENCODE) begin
            v = it.value_in;
            if (it.is_signed) begin
                v = (v << 1) ^ {FIELD_W{it.value_in[FIELD_W-1]}};
            end
            n = 0;
            while (v >= CONT_BIT && n < MAX_GROUPS - 1) begin
                r.out_byte = v[7:0] | CONT_BIT;
                r.byte_count = COUNT_W'(n + 1);
                r.last = 1'b0;
                pending_results.push_back(r);
                v = v >> GROUP_BITS;
                n++;
            end
            r.out_byte = v[7:0];
            r.byte_count = COUNT_W'(n + 1);
            r.last = 1'b1;
            pending_results.push_back(r);
            n_encodes++;
            n_enc_bytes += n + 1;
        end else begin
            n_dec_bytes++;
            if (dec_groups >= MAX_GROUPS) begin
                dec_groups = 0;
            end
            grp = FIELD_W'(it.data_byte & ~CONT_BIT);
            dec_acc = dec_acc | (grp << (GROUP_BITS * dec_groups));
            dec_groups++;
            more = (it.data_byte & CONT_BIT) != 0;
            tl = more && dec_groups >= MAX_GROUPS;
            unt = more && it.end_of_buffer;
            if (!more || tl || unt) begin
                v = dec_acc;
                if (it.is_signed) begin
                    v = (v >> 1) ^ {FIELD_W{v[0]}};
                end
                r.is_value = 1'b1;
                r.value_out = v;
                r.byte_count = COUNT_W'(dec_groups);
                r.last = 1'b1;
                r.unterminated = unt;
                r.too_long = tl;
                pending_results.push_back(r);
                dec_acc = '0;
                dec_groups = 0;
                n_values++;
                n_unterm += int'(unt);
                n_too_long += int'(tl);
            end
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: 0x%h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        compare_field("is_value", 32'(want.is_value), 32'(got.is_value));
        compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
        compare_field("value_out", want.value_out, got.value_out);
        compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
        compare_field("last", 32'(want.last), 32'(got.last));
        compare_field("unterminated", 32'(want.unterminated), 32'(got.unterminated));
        compare_field("too_long", 32'(want.too_long), 32'(got.too_long));
    endfunction

    always @(posedge aclk) begin
        in_xfer = aresetn && s_valid && s_ready;
        out_xfer = aresetn && m_valid && m_ready;
        if (in_xfer) begin
            predict_varint(s_data);
        end
        if (out_xfer) begin
            check_result(m_data);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_xfer) begin
            if (tx_wait > 0) begin
                s_valid <= 1'b0;
                tx_wait--;
            end else if (items_to_send.size() != 0) begin
                s_data <= items_to_send.pop_front();
                s_valid <= 1'b1;
                tx_wait = $urandom_range(0, tx_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver stall once, so the input side backs up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_checked >= 100) begin
            hold_done = 1;
            hold_left = 250;
            m_ready <= 1'b0;
        end else begin
            if (out_xfer) begin
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void queue_item(logic cmd, logic sgn, logic [31:0] val, logic [7:0] b,
                                       logic eob);
        in_item_t it;
        it.cmd = cmd;
        it.is_signed = sgn;
        it.value_in = val;
        it.data_byte = b;
        it.end_of_buffer = eob;
        items_to_send.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 300);
            1: return (32'd1 << (GROUP_BITS * $urandom_range(1, MAX_GROUPS - 1)))
                      - $urandom_range(0, 1);
            2: return -$urandom_range(1, 200);
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_encode();
        queue_item(CMD_ENCODE, 1'($urandom_range(0, 1)), pick_value(), 8'($urandom),
                   1'($urandom_range(0, 1)));
    endfunction

    // mostly well-formed byte runs; some cut short, some too long, some noise
    function automatic void queue_decode_run();
        int kind, n;
        logic [7:0] b;
        logic eob, fin;
        kind = $urandom_range(0, 9);
        n = $urandom_range(1, MAX_GROUPS);
        if (kind == 9) begin
            repeat ($urandom_range(1, 3)) begin
                queue_item(CMD_DECODE, 1'($urandom_range(0, 1)), $urandom, 8'($urandom),
                           1'($urandom_range(0, 1)));
            end
            return;
        end
        if (kind == 8) begin
            n = MAX_GROUPS;
        end
        for (int i = 0; i < n; i++) begin
            fin = (i == n - 1);
            b = 8'($urandom_range(0, 127));
            eob = 1'b0;
            if (!fin || kind >= 7) begin
                b = b | CONT_BIT;
            end
            if (fin) begin
                eob = (kind == 7) ? 1'b1 : 1'($urandom_range(0, 1));
            end
            queue_item(CMD_DECODE, 1'($urandom_range(0, 1)), $urandom, b, eob);
            if (!fin && $urandom_range(0, 7) == 0) begin
                queue_encode();
            end
        end
    endfunction

    task automatic wait_idle();
        while (items_to_send.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        #2_000_000;
        $display("timeout at %0t with %0d results outstanding", $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int tx_prof[6] = '{0, 6, 0, 6, 3, 6};
        int rx_prof[6] = '{0, 6, 6, 0, 3, 2};
        int goal;

        // encode corners: one and five bytes, zigzag extremes
        queue_item(CMD_ENCODE, 1'b0, 32'h0000_0000, 8'hFF, 1'b1);
        queue_item(CMD_ENCODE, 1'b0, 32'h0000_007F, 8'h00, 1'b0);
        queue_item(CMD_ENCODE, 1'b0, 32'h0000_0080, 8'hAA, 1'b1);
        queue_item(CMD_ENCODE, 1'b0, 32'hFFFF_FFFF, 8'h55, 1'b0);
        queue_item(CMD_ENCODE, 1'b1, 32'hFFFF_FFFF, 8'h80, 1'b1);
        queue_item(CMD_ENCODE, 1'b1, 32'h8000_0000, 8'h7F, 1'b0);
        queue_item(CMD_ENCODE, 1'b1, 32'h7FFF_FFFF, 8'h00, 1'b0);
        // single byte values, one ending the buffer
        queue_item(CMD_DECODE, 1'b0, 32'hFFFF_FFFF, 8'h00, 1'b1);
        queue_item(CMD_DECODE, 1'b1, 32'h0000_0000, 8'h01, 1'b0);
        // encode in the middle of a decode
        queue_item(CMD_DECODE, 1'b1, 32'h0, 8'h96, 1'b0);
        queue_item(CMD_ENCODE, 1'b0, 32'd300, 8'h01, 1'b0);
        queue_item(CMD_DECODE, 1'b0, 32'h0, 8'h01, 1'b0);
        // buffer ends on a continuation byte
        queue_item(CMD_DECODE, 1'b0, 32'h0, 8'h85, 1'b0);
        queue_item(CMD_DECODE, 1'b0, 32'h0, 8'h81, 1'b1);
        // too long, top group bits beyond the width dropped
        repeat (4) queue_item(CMD_DECODE, 1'b0, 32'h0, 8'h80, 1'b0);
        queue_item(CMD_DECODE, 1'b0, 32'h0, 8'hFF, 1'b0);
        // too long together with buffer end
        repeat (4) queue_item(CMD_DECODE, 1'b0, 32'h0, 8'hFF, 1'b0);
        queue_item(CMD_DECODE, 1'b1, 32'h0, 8'h8F, 1'b1);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        for (int chunk = 0; chunk < 6; chunk++) begin
            tx_gap_max = tx_prof[chunk];
            rx_gap_max = rx_prof[chunk];
            goal = items_queued + 52;
            while (items_queued < goal) begin
                if ($urandom_range(0, 4) < 2) begin
                    queue_encode();
                end else begin
                    queue_decode_run();
                end
            end
            if (chunk == 2) begin
                wait_idle();
            end else begin
                while (items_to_send.size() != 0) @(posedge aclk);
            end
        end
        wait_idle();
        repeat (10) @(posedge aclk);

        $display("sent %0d items: %0d encodes giving %0d bytes, %0d bytes decoded",
                 items_queued, n_encodes, n_enc_bytes, n_dec_bytes);
        $display("%0d values decoded (%0d unterminated, %0d too long), %0d results checked",
                 n_values, n_unterm, n_too_long, results_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
design/vzc_pkg.sv
design/vzc_decoder.sv
design/varint_zigzag_codec_unit.sv
design/vzc_checker.sv
tb/varint_zigzag_codec_unit_test.sv
